### rtl/axis_rotation_vertex_transform_macros.svh
// Assertion macros for the principal-axis vertex rotation block.
// No dependencies; included by files that carry concurrent checks.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef AXIS_ROTATION_VERTEX_TRANSFORM_MACROS_SVH
`define AXIS_ROTATION_VERTEX_TRANSFORM_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ARVT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define ARVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/arvt_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the
// principal-axis vertex rotation block. No dependencies.
`default_nettype none

package arvt_pkg;

    // Default widths
    localparam int COORD_WIDTH_DEF        = 32;
    localparam int TRIG_FRACTION_BITS_DEF = 15;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 17;
    localparam int AXIS_WIDTH      = 2;
    localparam int ANGLE_WIDTH     = 17;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROTATION_AXIS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE_UNITS   = 2'd1;

    // Axis codes; the remaining code passes vertices through
    localparam logic [AXIS_WIDTH-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_WIDTH-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_WIDTH-1:0] AXIS_Z = 2'd2;

    // Angle units: 1/128 degree
    localparam int TURN_UNITS         = 46080;
    localparam int HALF_TURN_UNITS    = 23040;
    localparam int QUARTER_TURN_UNITS = 11520;

    // CORDIC datapath
    localparam int CORDIC_STEPS    = 16;
    localparam int CORDIC_STEP_W   = $clog2(CORDIC_STEPS);
    localparam int CORDIC_FRAC     = 30;
    localparam int CORDIC_XY_WIDTH = 33;
    localparam int CORDIC_Z_WIDTH  = 24;
    localparam int ANGLE_Z_SHIFT   = 8;   // 1/128 deg -> 2^-15 deg

    localparam logic signed [CORDIC_XY_WIDTH-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    typedef enum logic [1:0] {
        TRIG_IDLE,
        TRIG_ITER,
        TRIG_ROUND
    } t_trig_state;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_trig_ctrl;

    // atan(2^-i) in 2^-15 degree
    function automatic logic signed [CORDIC_Z_WIDTH-1:0] atan_deg_q15(
        input logic [CORDIC_STEP_W-1:0] idx
    );
        case (idx)
            4'd0:    return 24'sd1474560;
            4'd1:    return 24'sd870484;
            4'd2:    return 24'sd459940;
            4'd3:    return 24'sd233473;
            4'd4:    return 24'sd117189;
            4'd5:    return 24'sd58652;
            4'd6:    return 24'sd29333;
            4'd7:    return 24'sd14667;
            4'd8:    return 24'sd7334;
            4'd9:    return 24'sd3667;
            4'd10:   return 24'sd1833;
            4'd11:   return 24'sd917;
            4'd12:   return 24'sd458;
            4'd13:   return 24'sd229;
            4'd14:   return 24'sd115;
            4'd15:   return 24'sd57;
            default: return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

### rtl/arvt_cordic.sv
// Iterative CORDIC that turns the configured angle into cached cosine
// and sine values. Depends on arvt_pkg.
`default_nettype none

module arvt_cordic
    import arvt_pkg::*;
#(
    parameter int TRIG_FRACTION_BITS = TRIG_FRACTION_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_start,
    input  wire  logic signed [ANGLE_WIDTH-1:0]  i_angle,
    output logic signed [TRIG_FRACTION_BITS+1:0] o_cos,
    output logic signed [TRIG_FRACTION_BITS+1:0] o_sin,
    output logic                                 o_busy
);

    localparam int TW    = TRIG_FRACTION_BITS + 2;
    localparam int AEW   = ANGLE_WIDTH + 1;
    localparam int XYW   = CORDIC_XY_WIDTH;
    localparam int ZW    = CORDIC_Z_WIDTH;
    localparam int SHIFT = CORDIC_FRAC - TRIG_FRACTION_BITS;

    localparam logic signed [XYW-1:0] RND_HALF = XYW'(1) << (SHIFT - 1);
    localparam logic signed [XYW-1:0] XY_ONE   = XYW'(1) << TRIG_FRACTION_BITS;

    t_trig_state r_state, n_state;
    t_trig_ctrl  ctrl;

    logic signed [XYW-1:0]     r_x, r_y;
    logic signed [ZW-1:0]      r_z;
    logic [CORDIC_STEP_W-1:0]  r_cnt;
    logic                      r_neg;
    logic signed [TW-1:0]      r_cos, r_sin;

    // Angle reduction into [-90, 90] degrees
    logic signed [AEW-1:0] a_ext, a_mod, a_half, a_quart;
    logic                  a_neg;

    always_comb begin
        a_ext = AEW'(i_angle);
        if (a_ext < -TURN_UNITS) begin
            a_mod = a_ext + AEW'(2 * TURN_UNITS);
        end else if (a_ext < 0) begin
            a_mod = a_ext + AEW'(TURN_UNITS);
        end else if (a_ext >= TURN_UNITS) begin
            a_mod = a_ext - AEW'(TURN_UNITS);
        end else begin
            a_mod = a_ext;
        end
        if (a_mod >= HALF_TURN_UNITS) begin
            a_half = a_mod - AEW'(TURN_UNITS);
        end else begin
            a_half = a_mod;
        end
        a_neg = 1'b0;
        if (a_half > QUARTER_TURN_UNITS) begin
            a_quart = a_half - AEW'(HALF_TURN_UNITS);
            a_neg   = 1'b1;
        end else if (a_half < -QUARTER_TURN_UNITS) begin
            a_quart = a_half + AEW'(HALF_TURN_UNITS);
            a_neg   = 1'b1;
        end else begin
            a_quart = a_half;
        end
    end

    // One micro-rotation per cycle
    logic signed [XYW-1:0] dx, dy;
    logic signed [ZW-1:0]  step_atan;

    always_comb begin
        dx        = r_y >>> r_cnt;
        dy        = r_x >>> r_cnt;
        step_atan = atan_deg_q15(r_cnt);
    end

    // Final rounding, sign fix and clamp to +-1.0
    logic signed [XYW-1:0] cos_rnd, sin_rnd, cos_fix, sin_fix, cos_clip, sin_clip;

    always_comb begin
        cos_rnd  = (r_x + RND_HALF) >>> SHIFT;
        sin_rnd  = (r_y + RND_HALF) >>> SHIFT;
        cos_fix  = r_neg ? -cos_rnd : cos_rnd;
        sin_fix  = r_neg ? -sin_rnd : sin_rnd;
        cos_clip = (cos_fix > XY_ONE) ? XY_ONE : ((cos_fix < -XY_ONE) ? -XY_ONE : cos_fix);
        sin_clip = (sin_fix > XY_ONE) ? XY_ONE : ((sin_fix < -XY_ONE) ? -XY_ONE : sin_fix);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            TRIG_IDLE:  if (i_start) n_state = TRIG_ITER;
            TRIG_ITER: begin
                if (!i_start && r_cnt == CORDIC_STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = TRIG_ROUND;
                end
            end
            TRIG_ROUND: n_state = i_start ? TRIG_ITER : TRIG_IDLE;
            default:    n_state = TRIG_IDLE;
        endcase
    end

    // Datapath controls; a new start always wins
    always_comb begin
        ctrl.load   = i_start;
        ctrl.step   = (r_state == TRIG_ITER)  && !i_start;
        ctrl.commit = (r_state == TRIG_ROUND) && !i_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TRIG_IDLE;
            r_cos   <= TW'(1) << TRIG_FRACTION_BITS;
            r_sin   <= '0;
        end else begin
            r_state <= n_state;
            if (ctrl.commit) begin
                r_cos <= cos_clip[TW-1:0];
                r_sin <= sin_clip[TW-1:0];
            end
        end
    end

    // Iteration registers
    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_x   <= CORDIC_GAIN_Q30;
            r_y   <= '0;
            r_z   <= ZW'(a_quart) <<< ANGLE_Z_SHIFT;
            r_neg <= a_neg;
            r_cnt <= '0;
        end else if (ctrl.step) begin
            if (!r_z[ZW-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - step_atan;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + step_atan;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_cos  = r_cos;
    assign o_sin  = r_sin;
    assign o_busy = (r_state != TRIG_IDLE);

endmodule

`default_nettype wire

### rtl/axis_rotation_vertex_transform.sv
// Top level: streams vertices through a rotation about a principal axis.
// Depends on arvt_pkg, arvt_cordic and the assertion macro header.
//
//  Channel   Direction  Signals                         Contents
//  s_axis    in         tvalid tready tdata             vertex x, y, z
//  m_axis    out        tvalid tready tdata tuser       rotated x, y, z; overflow
//  cfg       in         i_cfg_we i_cfg_index i_cfg_data axis (0), angle (1)
//
// One vertex per cycle sustained while m_axis_tready is high and no trig update runs;
// the pipeline is input register, product register, output register.
// A write to the axis or angle register starts the 16-step CORDIC;
// s_axis_tready stays low after the write while cosine and sine are rebuilt.
// Reset is synchronous, active low; it clears valids and config, and sets cos 1.0, sin 0.
// A stalled output holds; the pipeline keeps filling behind it.
`default_nettype none

`include "axis_rotation_vertex_transform_macros.svh"

module axis_rotation_vertex_transform
    import arvt_pkg::*;
#(
    parameter int COORD_WIDTH        = COORD_WIDTH_DEF,
    parameter int TRIG_FRACTION_BITS = TRIG_FRACTION_BITS_DEF
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    // vertex_x, vertex_y, vertex_z (low to high), zero padded to bytes
    input  wire  [((3*COORD_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    input  wire                                       s_axis_tvalid,
    output logic                                      s_axis_tready,
    // rotated_x, rotated_y, rotated_z (low to high), zero padded to bytes
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
    // overflow
    output logic                                      m_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire                                       m_axis_tready,
    input  wire                                       i_cfg_we,
    input  wire  [CFG_INDEX_WIDTH-1:0]                i_cfg_index,
    input  wire  [CFG_DATA_WIDTH-1:0]                 i_cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int F  = TRIG_FRACTION_BITS;
    localparam int TW = F + 2;
    localparam int PW = CW + TW;
    localparam int SW = PW + 1;

    localparam logic signed [SW-1:0] PROD_HALF = SW'(1) << (F - 1);
    localparam logic signed [TW-1:0] TRIG_ONE  = TW'(1) << F;

    // ---------------------------------------------------------------
    // Configuration registers and trig recompute trigger
    // ---------------------------------------------------------------
    logic [AXIS_WIDTH-1:0]         r_axis;
    logic signed [ANGLE_WIDTH-1:0] r_angle;
    logic                          r_trig_start;
    logic                          cfg_hit;

    assign cfg_hit = i_cfg_we &&
                     (i_cfg_index == REG_ROTATION_AXIS || i_cfg_index == REG_ANGLE_UNITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis       <= AXIS_X;
            r_angle      <= '0;
            r_trig_start <= 1'b0;
        end else begin
            r_trig_start <= cfg_hit;
            if (i_cfg_we && i_cfg_index == REG_ROTATION_AXIS) begin
                r_axis <= i_cfg_data[AXIS_WIDTH-1:0];
            end
            if (i_cfg_we && i_cfg_index == REG_ANGLE_UNITS) begin
                r_angle <= i_cfg_data[ANGLE_WIDTH-1:0];
            end
        end
    end

    logic signed [TW-1:0] w_cos, w_sin, w_nsin;
    logic                 w_cordic_busy;
    logic                 trig_busy;

    arvt_cordic #(
        .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_trig_start),
        .i_angle (r_angle),
        .o_cos   (w_cos),
        .o_sin   (w_sin),
        .o_busy  (w_cordic_busy)
    );

    assign trig_busy = r_trig_start || w_cordic_busy;
    assign w_nsin    = -w_sin;

    // ---------------------------------------------------------------
    // Pipeline flow control
    // ---------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;
    logic s_accept;

    assign adv3          = !r_v3 || m_axis_tready;
    assign adv2          = !r_v2 || adv3;
    assign adv1          = !r_v1 || adv2;
    assign s_axis_tready = adv1 && !trig_busy;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= s_accept;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------
    logic signed [CW-1:0] r1_x, r1_y, r1_z;

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r1_x <= $signed(s_axis_tdata[CW-1:0]);
            r1_y <= $signed(s_axis_tdata[2*CW-1:CW]);
            r1_z <= $signed(s_axis_tdata[3*CW-1:2*CW]);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: operand select and products
    // term0 = a0*p0 + b0*q0, term1 = a1*p1 + b1*q1
    // ---------------------------------------------------------------
    logic signed [CW-1:0] a0, b0, a1, b1;
    logic signed [TW-1:0] p0, q0, p1, q1;

    always_comb begin
        a0 = '0; b0 = '0; a1 = '0; b1 = '0;
        p0 = '0; q0 = '0; p1 = '0; q1 = '0;
        case (r_axis)
            AXIS_X: begin   // y' = y*c + z*s, z' = z*c - y*s
                a0 = r1_y; p0 = w_cos; b0 = r1_z; q0 = w_sin;
                a1 = r1_z; p1 = w_cos; b1 = r1_y; q1 = w_nsin;
            end
            AXIS_Y: begin   // x' = x*c - z*s, z' = x*s + z*c
                a0 = r1_x; p0 = w_cos; b0 = r1_z; q0 = w_nsin;
                a1 = r1_x; p1 = w_sin; b1 = r1_z; q1 = w_cos;
            end
            AXIS_Z: begin   // x' = x*c + y*s, y' = y*c - x*s
                a0 = r1_x; p0 = w_cos;  b0 = r1_y; q0 = w_sin;
                a1 = r1_x; p1 = w_nsin; b1 = r1_y; q1 = w_cos;
            end
            default: begin
                a0 = '0;
            end
        endcase
    end

    logic signed [PW-1:0] r2_pa0, r2_pb0, r2_pa1, r2_pb1;
    logic signed [CW-1:0] r2_x, r2_y, r2_z;

    always_ff @(posedge i_clk) begin
        if (r_v1 && adv2) begin
            r2_pa0 <= a0 * p0;
            r2_pb0 <= b0 * q0;
            r2_pa1 <= a1 * p1;
            r2_pb1 <= b1 * q1;
            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_z   <= r1_z;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: sum, round half up, saturate
    // ---------------------------------------------------------------
    // Returns {overflow, value}
    function automatic logic [CW:0] round_sat(
        input logic signed [PW-1:0] pa,
        input logic signed [PW-1:0] pb
    );
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] sh;
        logic [SW-CW:0]       hi;
        sum = SW'(pa) + SW'(pb) + PROD_HALF;
        sh  = sum >>> F;
        hi  = sh[SW-1:CW-1];
        if ((&hi) || !(|hi)) begin
            return {1'b0, sh[CW-1:0]};
        end else if (sh[SW-1]) begin
            return {1'b1, 1'b1, {(CW-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    logic [CW:0]          t0, t1;
    logic signed [CW-1:0] n_ox, n_oy, n_oz;
    logic                 n_ovf;

    always_comb begin
        t0    = round_sat(r2_pa0, r2_pb0);
        t1    = round_sat(r2_pa1, r2_pb1);
        n_ox  = r2_x;
        n_oy  = r2_y;
        n_oz  = r2_z;
        n_ovf = 1'b0;
        case (r_axis)
            AXIS_X: begin
                n_oy  = t0[CW-1:0];
                n_oz  = t1[CW-1:0];
                n_ovf = t0[CW] || t1[CW];
            end
            AXIS_Y: begin
                n_ox  = t0[CW-1:0];
                n_oz  = t1[CW-1:0];
                n_ovf = t0[CW] || t1[CW];
            end
            AXIS_Z: begin
                n_ox  = t0[CW-1:0];
                n_oy  = t1[CW-1:0];
                n_ovf = t0[CW] || t1[CW];
            end
            default: begin
                n_ovf = 1'b0;   // pass-through code
            end
        endcase
    end

    logic signed [CW-1:0] r_ox, r_oy, r_oz;
    logic                 r_ovf;

    always_ff @(posedge i_clk) begin
        if (r_v2 && adv3) begin
            r_ox  <= n_ox;
            r_oy  <= n_oy;
            r_oz  <= n_oz;
            r_ovf <= n_ovf;
        end
    end

    // Output packing
    always_comb begin
        m_axis_tdata               = '0;
        m_axis_tdata[CW-1:0]       = r_ox;
        m_axis_tdata[2*CW-1:CW]    = r_oy;
        m_axis_tdata[3*CW-1:2*CW]  = r_oz;
    end

    assign m_axis_tuser  = r_ovf;
    assign m_axis_tvalid = r_v3;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic pass_valid;
    logic trig_in_range;

    assign pass_valid    = m_axis_tvalid &&
                           (r_axis != AXIS_X) && (r_axis != AXIS_Y) && (r_axis != AXIS_Z);
    assign trig_in_range = (w_cos <= TRIG_ONE) && (w_cos >= -TRIG_ONE) &&
                           (w_sin <= TRIG_ONE) && (w_sin >= -TRIG_ONE);

    // A write to the axis or angle register must hold off new vertices while trig is rebuilt
    `ARVT_ASSERT_NEXT(a_cfg_holds_input, cfg_hit, !s_axis_tready, "input taken during trig update")
    // The pass-through axis code never flags overflow
    `ARVT_ASSERT_SAME(a_pass_no_ovf, pass_valid, !m_axis_tuser, "overflow on pass-through axis")
    // Cached trig values stay within +-1.0
    `ARVT_ASSERT_SAME(a_trig_range, 1'b1, trig_in_range, "cached trig out of range")

endmodule

`default_nettype wire
